### rtl/block_sparse_column_spmv_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sparse column SpMV engine
// Shared property shapes used by the port checker.
// ----------------------------------------------------------------------------
`ifndef BLOCK_SPARSE_COLUMN_SPMV_DEFINES_SVH
`define BLOCK_SPARSE_COLUMN_SPMV_DEFINES_SVH

// Consequent must hold in the cycle after the antecedent, outside reset.
`define BSCS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bscs port check failed");

// Consequent must hold in the cycle after reset is seen high.
`define BSCS_ASSERT_AFTER_RESET(lbl, clk, rst, cons) \
   lbl: assert property (@(posedge clk) (rst) |=> (cons)) \
      else $error("bscs reset check failed");

`endif

### rtl/bscs_pkg.sv
// ----------------------------------------------------------------------------
// bscs_pkg
// Types and fixed constants shared by the sparse column SpMV engine.
// ----------------------------------------------------------------------------
`default_nettype none

package bscs_pkg;

   localparam int unsigned ROW_W   = 12;
   localparam int unsigned HALF_W  = 16;
   localparam int unsigned WORD_W  = 32;
   localparam int unsigned LANES   = 4;
   localparam int unsigned LANE_W  = $clog2(LANES);
   localparam int unsigned Q_DEPTH = 2;

   localparam logic OP_ACC  = 1'b0;
   localparam logic OP_READ = 1'b1;

   localparam logic [WORD_W-1:0] CANON_NAN = 32'h7FC0_0000;
   localparam logic [WORD_W-1:0] POS_INF   = 32'h7F80_0000;

   // one queued transaction, weights already widened to fp32
   typedef struct packed {
      logic                             opcode;
      logic [ROW_W-1:0]                 row;
      logic [LANES-1:0][WORD_W-1:0]     weight;
      logic [WORD_W-1:0]                x_value;
   } entry_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_NEXT,
      ST_RD,
      ST_MNORM,
      ST_MRND,
      ST_ALIGN,
      ST_SUM,
      ST_ANORM,
      ST_ARND,
      ST_RSP
   } state_type;

endpackage

`default_nettype wire

### rtl/bscs_front.sv
// ----------------------------------------------------------------------------
// bscs_front
// Accepts request transactions, widens the fp16 weights and queues them.
// ----------------------------------------------------------------------------
`default_nettype none

module bscs_front (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         accept_en,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic                         req_opcode,
   input  wire logic [bscs_pkg::ROW_W-1:0]   req_row,
   input  wire logic [bscs_pkg::HALF_W-1:0]  req_weight_0,
   input  wire logic [bscs_pkg::HALF_W-1:0]  req_weight_1,
   input  wire logic [bscs_pkg::HALF_W-1:0]  req_weight_2,
   input  wire logic [bscs_pkg::HALF_W-1:0]  req_weight_3,
   input  wire logic [bscs_pkg::WORD_W-1:0]  req_x_value,
   output logic                              q_valid,
   input  wire logic                         q_ready,
   output bscs_pkg::entry_type               q_entry
);

   localparam int unsigned PTR_W = $clog2(bscs_pkg::Q_DEPTH);
   localparam int unsigned CNT_W = $clog2(bscs_pkg::Q_DEPTH + 1);

   // exact fp16 to fp32 widening
   function automatic logic [31:0] half_to_f32(input logic [15:0] h);
      logic [4:0] ex;
      logic [9:0] man;
      logic [3:0] lz;
      logic       hit;
      logic [9:0] nm;
      logic [31:0] res;
      ex  = h[14:10];
      man = h[9:0];
      lz  = '0;
      hit = 1'b0;
      for (int i = 9; i >= 0; i--) begin
         if (!hit) begin
            if (man[i]) hit = 1'b1;
            else        lz  = lz + 4'd1;
         end
      end
      nm = 10'({1'b0, man} << (lz + 4'd1));
      if (ex == 5'h1F) begin
         res = {h[15], 8'hFF, man, 13'b0};
      end else if (ex == 5'd0) begin
         if (man == 10'd0) res = {h[15], 31'b0};
         else              res = {h[15], 8'(8'd112 - {4'b0, lz}), nm, 13'b0};
      end else begin
         res = {h[15], 8'({3'b0, ex} + 8'd112), man, 13'b0};
      end
      return res;
   endfunction

   bscs_pkg::entry_type queue_ff [bscs_pkg::Q_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   bscs_pkg::entry_type new_entry;
   logic                push, pop;

   // classify and widen the incoming transaction
   always_comb begin
      new_entry.opcode    = req_opcode;
      new_entry.row       = req_row;
      new_entry.weight[0] = half_to_f32(req_weight_0);
      new_entry.weight[1] = half_to_f32(req_weight_1);
      new_entry.weight[2] = half_to_f32(req_weight_2);
      new_entry.weight[3] = half_to_f32(req_weight_3);
      new_entry.x_value   = req_x_value;
   end

   assign req_ready = accept_en && (count_ff != CNT_W'(bscs_pkg::Q_DEPTH));
   assign push      = req_valid && req_ready;
   assign q_valid   = (count_ff != '0);
   assign pop       = q_valid && q_ready;
   assign q_entry   = queue_ff[rd_ptr_ff];

   // queue pointers
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) wr_ptr_in = PTR_W'((int'(wr_ptr_ff) + 1) % bscs_pkg::Q_DEPTH);
      if (pop)  rd_ptr_in = PTR_W'((int'(rd_ptr_ff) + 1) % bscs_pkg::Q_DEPTH);
      if (push && !pop)      count_in = count_ff + CNT_W'(1);
      else if (pop && !push) count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage, no reset
   always_ff @(posedge clock) begin
      if (push) queue_ff[wr_ptr_ff] <= new_entry;
   end

endmodule

`default_nettype wire

### rtl/bscs_back.sv
// ----------------------------------------------------------------------------
// bscs_back
// Sequencer with the accumulator memory, fp32 multiply and fp32 add.
// ----------------------------------------------------------------------------
`default_nettype none

module bscs_back #(
   parameter int unsigned OUT_ROWS   = 4096,
   parameter int unsigned BLOCK_ROWS = 4
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   output logic                              accept_en,
   input  wire logic                         q_valid,
   output logic                              q_ready,
   input  wire bscs_pkg::entry_type          q_entry,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic [bscs_pkg::WORD_W-1:0]       rsp_read_value
);

   localparam int unsigned AW    = $clog2(OUT_ROWS);
   localparam int unsigned EXT_W = ((AW > bscs_pkg::ROW_W) ? AW : bscs_pkg::ROW_W) + 2;
   localparam int unsigned NUSE  = (BLOCK_ROWS < bscs_pkg::LANES) ? BLOCK_ROWS
                                                                  : bscs_pkg::LANES;
   localparam int unsigned IDX_W = bscs_pkg::LANE_W + 1;

   // leading zero count of the raw significand
   function automatic logic [5:0] lzc48(input logic [47:0] v);
      logic [5:0] n;
      logic       hit;
      n   = '0;
      hit = 1'b0;
      for (int i = 47; i >= 0; i--) begin
         if (!hit) begin
            if (v[i]) hit = 1'b1;
            else      n   = n + 6'd1;
         end
      end
      return n;
   endfunction

   // round to nearest even and pack, n has its leading one at bit 47
   function automatic logic [31:0] round_pack(input logic s,
                                              input logic signed [11:0] e,
                                              input logic [47:0] n);
      logic [11:0] sh;
      logic [47:0] nd;
      logic        stk;
      logic [23:0] m;
      logic        g;
      logic [24:0] mr;
      logic [7:0]  ef;
      logic [32:0] tot;
      logic [31:0] res;
      sh  = '0;
      nd  = n;
      stk = 1'b0;
      ef  = '0;
      if (e >= 12'sd255) begin
         res = {s, bscs_pkg::POS_INF[30:0]};
      end else begin
         if (e <= 12'sd0) begin
            sh = 12'(12'sd1 - e);
            if (sh >= 12'd48) begin
               nd  = '0;
               stk = |n;
            end else begin
               nd  = n >> sh;
               stk = |(n & ~({48{1'b1}} << sh));
            end
         end else begin
            ef = 8'(e - 12'sd1);
         end
         m   = nd[47:24];
         g   = nd[23];
         stk = stk | (|nd[22:0]);
         mr  = {1'b0, m} + 25'(g & (stk | m[0]));
         tot = {2'b0, ef, 23'b0} + {8'b0, mr};
         if (tot[32:23] >= 10'd255) res = {s, bscs_pkg::POS_INF[30:0]};
         else                       res = {s, tot[30:0]};
      end
      return res;
   endfunction

   bscs_pkg::state_type state_ff, state_in;
   bscs_pkg::entry_type cur_ff;
   logic [IDX_W-1:0]    idx_ff;
   logic [AW-1:0]       clr_ff;
   logic [31:0]         mem [OUT_ROWS];
   logic [31:0]         mem_q_ff;
   logic [47:0]         raw_ff;
   logic signed [11:0]  raw_e_ff;
   logic                raw_s_ff;
   logic [47:0]         nrm_ff;
   logic signed [11:0]  nrm_e_ff;
   logic                spec_ff;
   logic [31:0]         spec_val_ff;
   logic [31:0]         prod_ff;
   logic [26:0]         big_ff, small_ff;
   logic                sub_ff;
   logic [7:0]          ebig_ff;
   logic                rsp_valid_ff;
   logic [31:0]         rsp_data_ff;

   logic [EXT_W-1:0]    row_ext;
   logic [AW-1:0]       addr;
   logic                in_range;
   logic                mem_re, mem_we;
   logic [AW-1:0]       mem_wa;
   logic [31:0]         mem_wd;
   logic [31:0]         rnd_res;
   logic                take;

   assign row_ext  = EXT_W'(cur_ff.row) + EXT_W'(idx_ff);
   assign addr     = row_ext[AW-1:0];
   assign in_range = (row_ext < EXT_W'(OUT_ROWS));
   assign rnd_res  = spec_ff ? spec_val_ff : round_pack(raw_s_ff, nrm_e_ff, nrm_ff);
   assign take     = q_valid && (q_entry.opcode == bscs_pkg::OP_ACC || !rsp_valid_ff);

   // next state and control
   always_comb begin
      state_in  = state_ff;
      q_ready   = 1'b0;
      mem_re    = 1'b0;
      mem_we    = 1'b0;
      mem_wa    = addr;
      mem_wd    = '0;
      accept_en = (state_ff != bscs_pkg::ST_CLEAR);
      unique case (state_ff)
         bscs_pkg::ST_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = clr_ff;
            if (clr_ff == AW'(OUT_ROWS - 1)) state_in = bscs_pkg::ST_IDLE;
         end
         bscs_pkg::ST_IDLE: begin
            q_ready = take;
            if (take) begin
               state_in = (q_entry.opcode == bscs_pkg::OP_READ) ? bscs_pkg::ST_RD
                                                                 : bscs_pkg::ST_NEXT;
            end
         end
         bscs_pkg::ST_NEXT: begin
            if (idx_ff == IDX_W'(NUSE) || !in_range) state_in = bscs_pkg::ST_IDLE;
            else                                      state_in = bscs_pkg::ST_RD;
         end
         bscs_pkg::ST_RD: begin
            mem_re   = 1'b1;
            state_in = (cur_ff.opcode == bscs_pkg::OP_READ) ? bscs_pkg::ST_RSP
                                                            : bscs_pkg::ST_MNORM;
         end
         bscs_pkg::ST_MNORM: state_in = bscs_pkg::ST_MRND;
         bscs_pkg::ST_MRND:  state_in = bscs_pkg::ST_ALIGN;
         bscs_pkg::ST_ALIGN: state_in = bscs_pkg::ST_SUM;
         bscs_pkg::ST_SUM:   state_in = bscs_pkg::ST_ANORM;
         bscs_pkg::ST_ANORM: state_in = bscs_pkg::ST_ARND;
         bscs_pkg::ST_ARND: begin
            mem_we   = 1'b1;
            mem_wd   = rnd_res;
            state_in = bscs_pkg::ST_NEXT;
         end
         bscs_pkg::ST_RSP: begin
            mem_we   = in_range;
            state_in = bscs_pkg::ST_IDLE;
         end
         default: state_in = bscs_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= bscs_pkg::ST_CLEAR;
      else       state_ff <= state_in;
   end

   // control registers: clear sweep, row index, response slot
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (state_ff == bscs_pkg::ST_CLEAR) clr_ff <= clr_ff + AW'(1);
         if (state_ff == bscs_pkg::ST_IDLE && take) idx_ff <= '0;
         else if (state_ff == bscs_pkg::ST_ARND)    idx_ff <= idx_ff + IDX_W'(1);
         if (state_ff == bscs_pkg::ST_RSP) rsp_valid_ff <= 1'b1;
         else if (rsp_ready)               rsp_valid_ff <= 1'b0;
      end
   end

   // accumulator memory, registered read
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      if (mem_re) mem_q_ff <= mem[addr];
   end

   // arithmetic datapath
   always_ff @(posedge clock) begin : datapath
      logic [31:0] a, b;
      logic [7:0]  ea, eb, eav, ebv, d;
      logic [22:0] fa, fb;
      logic [23:0] ma, mb, mbig, msml;
      logic        anan, bnan, ainf, binf, azero, bzero, a_big;
      logic [26:0] sml_ext;
      logic [27:0] sum;
      logic [5:0]  lz;
      a = '0; b = '0; ea = '0; eb = '0; eav = '0; ebv = '0; d = '0;
      fa = '0; fb = '0; ma = '0; mb = '0; mbig = '0; msml = '0;
      anan = 1'b0; bnan = 1'b0; ainf = 1'b0; binf = 1'b0;
      azero = 1'b0; bzero = 1'b0; a_big = 1'b0; sml_ext = '0; sum = '0; lz = '0;
      if (state_ff == bscs_pkg::ST_IDLE && take) cur_ff <= q_entry;
      case (state_ff)
         // multiply: specials and significand product
         bscs_pkg::ST_RD: begin
            a = cur_ff.weight[idx_ff[bscs_pkg::LANE_W-1:0]];
            b = cur_ff.x_value;
            ea = a[30:23]; eb = b[30:23]; fa = a[22:0]; fb = b[22:0];
            anan  = (ea == 8'hFF) && (fa != '0);
            bnan  = (eb == 8'hFF) && (fb != '0);
            ainf  = (ea == 8'hFF) && (fa == '0);
            binf  = (eb == 8'hFF) && (fb == '0);
            azero = (ea == 8'h00) && (fa == '0);
            bzero = (eb == 8'h00) && (fb == '0);
            eav = (ea == 8'h00) ? 8'd1 : ea;
            ebv = (eb == 8'h00) ? 8'd1 : eb;
            ma  = {ea != 8'h00, fa};
            mb  = {eb != 8'h00, fb};
            raw_ff   <= ma * mb;
            raw_e_ff <= $signed({4'b0, eav}) + $signed({4'b0, ebv}) - 12'sd126;
            raw_s_ff <= a[31] ^ b[31];
            spec_ff  <= anan || bnan || ainf || binf || azero || bzero;
            if (anan || bnan || (ainf && bzero) || (binf && azero))
               spec_val_ff <= bscs_pkg::CANON_NAN;
            else if (ainf || binf)
               spec_val_ff <= {a[31] ^ b[31], bscs_pkg::POS_INF[30:0]};
            else
               spec_val_ff <= {a[31] ^ b[31], 31'b0};
         end
         // shared normalise step
         bscs_pkg::ST_MNORM, bscs_pkg::ST_ANORM: begin
            lz = lzc48(raw_ff);
            nrm_ff   <= raw_ff << lz;
            nrm_e_ff <= raw_e_ff - $signed({6'b0, lz});
         end
         bscs_pkg::ST_MRND: prod_ff <= rnd_res;
         // add: specials and alignment of the smaller operand
         bscs_pkg::ST_ALIGN: begin
            a = mem_q_ff;
            b = prod_ff;
            ea = a[30:23]; eb = b[30:23]; fa = a[22:0]; fb = b[22:0];
            anan  = (ea == 8'hFF) && (fa != '0);
            bnan  = (eb == 8'hFF) && (fb != '0);
            ainf  = (ea == 8'hFF) && (fa == '0);
            binf  = (eb == 8'hFF) && (fb == '0);
            azero = (ea == 8'h00) && (fa == '0);
            bzero = (eb == 8'h00) && (fb == '0);
            eav = (ea == 8'h00) ? 8'd1 : ea;
            ebv = (eb == 8'h00) ? 8'd1 : eb;
            ma  = {ea != 8'h00, fa};
            mb  = {eb != 8'h00, fb};
            a_big = (a[30:0] >= b[30:0]);
            mbig  = a_big ? ma : mb;
            msml  = a_big ? mb : ma;
            d     = a_big ? (eav - ebv) : (ebv - eav);
            if (d >= 8'd27) begin
               sml_ext = {26'b0, |msml};
            end else begin
               sml_ext = ({msml, 3'b0} >> d)
                       | 27'(|({msml, 3'b0} & ~({27{1'b1}} << d)));
            end
            big_ff   <= {mbig, 3'b0};
            small_ff <= sml_ext;
            sub_ff   <= a[31] ^ b[31];
            ebig_ff  <= a_big ? eav : ebv;
            raw_s_ff <= a_big ? a[31] : b[31];
            spec_ff  <= anan || bnan || ainf || binf || azero || bzero;
            if (anan || bnan || (ainf && binf && (a[31] != b[31])))
               spec_val_ff <= bscs_pkg::CANON_NAN;
            else if (ainf)
               spec_val_ff <= a;
            else if (binf)
               spec_val_ff <= b;
            else if (azero && bzero)
               spec_val_ff <= {a[31] & b[31], 31'b0};
            else if (azero)
               spec_val_ff <= b;
            else
               spec_val_ff <= a;
         end
         // add or subtract aligned significands
         bscs_pkg::ST_SUM: begin
            sum = sub_ff ? ({1'b0, big_ff} - {1'b0, small_ff})
                         : ({1'b0, big_ff} + {1'b0, small_ff});
            raw_ff   <= {sum, 20'b0};
            raw_e_ff <= $signed({4'b0, ebig_ff}) + 12'sd1;
            if (!spec_ff && sum == '0) begin
               spec_ff     <= 1'b1;
               spec_val_ff <= '0;
            end
         end
         default: begin
         end
      endcase
   end

   // response register
   always_ff @(posedge clock) begin
      if (state_ff == bscs_pkg::ST_RSP) rsp_data_ff <= in_range ? mem_q_ff : '0;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_data_ff;

endmodule

`default_nettype wire

### rtl/block_sparse_column_spmv.sv
// ----------------------------------------------------------------------------
// block_sparse_column_spmv
// Sparse matrix times vector engine with fp16 weight blocks, fp32 sums.
// ----------------------------------------------------------------------------
// Usage:
//  - req_* carries one transaction: an accumulate of four fp16 weights times
//    an fp32 x into rows row..row+3, or a read-and-clear of one row.
//  - rsp_* returns the fp32 value for each read; accumulates give no response.
//  - Both channels are valid/ready. Two transactions queue behind the engine,
//    so the host keeps sending while a response waits on rsp_ready.
//  - An accumulate steps through read, multiply normalise, multiply round,
//    align, add, add normalise, round and write for each row in range, one
//    row at a time, on the single shared fp sequencer and one accumulator
//    memory port.
//  - A read passes through the read and response states after leaving the
//    queue; a new read starts only once the previous response has been taken.
//  - After reset a clearing sweep writes zero to all OUT_ROWS accumulators,
//    one per cycle; req_ready stays low until the sweep ends.
//  - When rsp_ready is low the response holds and later reads wait.
// ----------------------------------------------------------------------------
`default_nettype none

module block_sparse_column_spmv #(
   parameter int unsigned OUT_ROWS   = 4096,
   parameter int unsigned BLOCK_ROWS = 4
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic                         req_opcode,
   input  wire logic [bscs_pkg::ROW_W-1:0]   req_row,
   input  wire logic [bscs_pkg::HALF_W-1:0]  req_weight_0,
   input  wire logic [bscs_pkg::HALF_W-1:0]  req_weight_1,
   input  wire logic [bscs_pkg::HALF_W-1:0]  req_weight_2,
   input  wire logic [bscs_pkg::HALF_W-1:0]  req_weight_3,
   input  wire logic [bscs_pkg::WORD_W-1:0]  req_x_value,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic [bscs_pkg::WORD_W-1:0]       rsp_read_value
);

   logic                accept_en;
   logic                q_valid;
   logic                q_ready;
   bscs_pkg::entry_type q_entry;

   // intake and queue
   bscs_front u_front (
      .clock        (clock),
      .reset        (reset),
      .accept_en    (accept_en),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_opcode   (req_opcode),
      .req_row      (req_row),
      .req_weight_0 (req_weight_0),
      .req_weight_1 (req_weight_1),
      .req_weight_2 (req_weight_2),
      .req_weight_3 (req_weight_3),
      .req_x_value  (req_x_value),
      .q_valid      (q_valid),
      .q_ready      (q_ready),
      .q_entry      (q_entry)
   );

   // execution engine
   bscs_back #(
      .OUT_ROWS   (OUT_ROWS),
      .BLOCK_ROWS (BLOCK_ROWS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .accept_en      (accept_en),
      .q_valid        (q_valid),
      .q_ready        (q_ready),
      .q_entry        (q_entry),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_read_value (rsp_read_value)
   );

endmodule

`default_nettype wire

### rtl/bscs_checker.sv
// ----------------------------------------------------------------------------
// bscs_checker
// Port level checks for the sparse column SpMV engine, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "block_sparse_column_spmv_defines.svh"

module bscs_checker (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         req_ready,
   input wire logic                         rsp_valid,
   input wire logic                         rsp_ready,
   input wire logic [bscs_pkg::WORD_W-1:0]  rsp_read_value
);

   // clearing sweep keeps the request side closed straight after reset
   `BSCS_ASSERT_AFTER_RESET(a_ready_low_after_reset, clock, reset, !req_ready)

   // no response survives reset
   `BSCS_ASSERT_AFTER_RESET(a_no_rsp_after_reset, clock, reset, !rsp_valid)

   // a stalled response holds its value
   `BSCS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
                     rsp_valid && $stable(rsp_read_value))

   // a new read waits for the previous response, so responses never come back to back
   `BSCS_ASSERT_NEXT(a_rsp_gap, clock, reset, rsp_valid && rsp_ready, !rsp_valid)

endmodule

bind block_sparse_column_spmv bscs_checker u_bscs_checker (.*);

`default_nettype wire

### bench/spmv_result_checker.sv
// ----------------------------------------------------------------------------
// Result checker for the sparse column SpMV engine
// Watches both channels, keeps its own copy of the fp32 accumulators, works
// out each read result and compares it with what the engine returns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spmv_result_checker (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   input  wire logic                          req_ready,
   input  wire logic                          req_opcode,
   input  wire logic [bscs_pkg::ROW_W-1:0]    req_row,
   input  wire logic [bscs_pkg::HALF_W-1:0]   req_weight_0,
   input  wire logic [bscs_pkg::HALF_W-1:0]   req_weight_1,
   input  wire logic [bscs_pkg::HALF_W-1:0]   req_weight_2,
   input  wire logic [bscs_pkg::HALF_W-1:0]   req_weight_3,
   input  wire logic [bscs_pkg::WORD_W-1:0]   req_x_value,
   input  wire logic                          rsp_valid,
   input  wire logic                          rsp_ready,
   input  wire logic [bscs_pkg::WORD_W-1:0]   rsp_read_value,
   output int                                 err_count,
   output int                                 pending
);

   localparam int unsigned NUM_ROWS = 4096;

   logic [bscs_pkg::WORD_W-1:0] acc_model [NUM_ROWS];
   logic [bscs_pkg::WORD_W-1:0] read_expected [$];

   function automatic logic is_nan(input logic [31:0] f);
      return (f[30:23] == 8'hFF) && (f[22:0] != 0);
   endfunction

   function automatic logic is_inf(input logic [31:0] f);
      return (f[30:23] == 8'hFF) && (f[22:0] == 0);
   endfunction

   // exact fp16 to fp32 widening
   function automatic logic [31:0] half_to_single(input logic [15:0] h);
      logic [31:0] sgn;
      logic [4:0]  ex;
      logic [10:0] man;
      int          e32;
      sgn = {h[15], 31'b0};
      ex  = h[14:10];
      man = {1'b0, h[9:0]};
      if (ex == 5'h1F) return sgn | 32'h7F80_0000 | (32'(man[9:0]) << 13);
      if (ex == 0) begin
         if (man == 0) return sgn;
         e32 = 113;
         while (!man[10]) begin
            man = man << 1;
            e32--;
         end
         return sgn | (32'(e32) << 23) | (32'(man[9:0]) << 13);
      end
      return sgn | ((32'(ex) + 112) << 23) | (32'(man[9:0]) << 13);
   endfunction

   // value = mag * 2^lsb_exp; round to fp32, nearest even, subnormals kept
   function automatic logic [31:0] round_single(input logic sgn, input int lsb_exp,
                                                 input logic [79:0] mag);
      int          msb;
      int          shift;
      int          bexp;
      logic [79:0] kept;
      logic [79:0] rem;
      logic [79:0] half;
      logic [63:0] enc;
      if (mag == 0) return {sgn, 31'b0};
      msb = 79;
      while (!mag[msb]) msb--;
      bexp = msb + lsb_exp + 127;
      shift = (bexp >= 1) ? msb - 23 : -149 - lsb_exp;
      if (shift >= 80) begin
         kept = 0;
      end else if (shift > 0) begin
         kept = mag >> shift;
         rem  = mag & ((80'd1 << shift) - 1);
         half = 80'd1 << (shift - 1);
         if (rem > half || (rem == half && kept[0])) kept = kept + 1;
      end else begin
         kept = mag << (-shift);
      end
      enc = (bexp >= 1) ? (64'(bexp - 1) << 23) + kept[63:0] : kept[63:0];
      if (enc >= 64'h7F80_0000) return {sgn, 8'hFF, 23'b0};
      return {sgn, enc[30:0]};
   endfunction

   function automatic logic [23:0] mant_of(input logic [31:0] f);
      return (f[30:23] == 0) ? {1'b0, f[22:0]} : {1'b1, f[22:0]};
   endfunction

   function automatic int lsb_exp_of(input logic [31:0] f);
      return ((f[30:23] == 0) ? 1 : int'(f[30:23])) - 150;
   endfunction

   function automatic logic [31:0] single_mul(input logic [31:0] a, input logic [31:0] b);
      logic sgn;
      sgn = a[31] ^ b[31];
      if (is_nan(a) || is_nan(b)) return bscs_pkg::CANON_NAN;
      if (is_inf(a) || is_inf(b)) begin
         if (a[30:0] == 0 || b[30:0] == 0) return bscs_pkg::CANON_NAN;
         return {sgn, 8'hFF, 23'b0};
      end
      return round_single(sgn, lsb_exp_of(a) + lsb_exp_of(b),
                          80'(mant_of(a)) * 80'(mant_of(b)));
   endfunction

   function automatic logic [31:0] single_add(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] big;
      logic [31:0] tiny;
      logic [79:0] mag_big;
      logic [79:0] mag_tiny;
      int          diff;
      if (is_nan(a) || is_nan(b)) return bscs_pkg::CANON_NAN;
      if (is_inf(a) && is_inf(b)) return (a[31] == b[31]) ? a : bscs_pkg::CANON_NAN;
      if (is_inf(a)) return a;
      if (is_inf(b)) return b;
      if (a[30:0] >= b[30:0]) begin
         big = a; tiny = b;
      end else begin
         big = b; tiny = a;
      end
      // smaller operand far below only counts as a sticky bit
      diff = lsb_exp_of(big) - lsb_exp_of(tiny);
      mag_big = 80'(mant_of(big)) << 40;
      mag_tiny = (diff <= 40) ? 80'(mant_of(tiny)) << (40 - diff)
                              : 80'(mant_of(tiny) != 0);
      if (big[31] == tiny[31])
         return round_single(big[31], lsb_exp_of(big) - 40, mag_big + mag_tiny);
      if (mag_big == mag_tiny) return 32'h0;
      return round_single(big[31], lsb_exp_of(big) - 40, mag_big - mag_tiny);
   endfunction

   // update the accumulator copy for one accepted transaction
   task automatic apply_transaction();
      logic [15:0] wts [4];
      logic [31:0] prod;
      int          r;
      wts[0] = req_weight_0;
      wts[1] = req_weight_1;
      wts[2] = req_weight_2;
      wts[3] = req_weight_3;
      if (req_opcode == bscs_pkg::OP_READ) begin
         read_expected.push_back(acc_model[req_row]);
         acc_model[req_row] = '0;
      end else begin
         for (int n = 0; n < 4; n++) begin
            r = int'(req_row) + n;
            if (r < NUM_ROWS) begin
               prod = single_mul(half_to_single(wts[n]), req_x_value);
               acc_model[r] = single_add(acc_model[r], prod);
            end
         end
      end
   endtask

   initial begin
      err_count = 0;
      pending   = 0;
      foreach (acc_model[i]) acc_model[i] = '0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) apply_transaction();
         if (rsp_valid && rsp_ready) begin
            if (read_expected.size() == 0) begin
               $error("read_value with no read outstanding: actual %h", rsp_read_value);
               err_count++;
            end else if (read_expected[0] !== rsp_read_value) begin
               $error("read_value mismatch: expected %h, actual %h",
                      read_expected[0], rsp_read_value);
               err_count++;
               void'(read_expected.pop_front());
            end else begin
               void'(read_expected.pop_front());
            end
         end
      end
      pending = read_expected.size();
   end

endmodule

`default_nettype wire

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// Testbench top for the sparse column SpMV engine
// Drives directed and random accumulate and read transactions with random
// idling on both channels and one long response hold-off; the checker
// predicts every read value and counts mismatches.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_top;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic                          req_opcode = bscs_pkg::OP_ACC;
   logic [bscs_pkg::ROW_W-1:0]    req_row = '0;
   logic [bscs_pkg::HALF_W-1:0]   req_weight_0 = '0;
   logic [bscs_pkg::HALF_W-1:0]   req_weight_1 = '0;
   logic [bscs_pkg::HALF_W-1:0]   req_weight_2 = '0;
   logic [bscs_pkg::HALF_W-1:0]   req_weight_3 = '0;
   logic [bscs_pkg::WORD_W-1:0]   req_x_value = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic [bscs_pkg::WORD_W-1:0]   rsp_read_value;

   int   err_count;
   int   pending;
   logic idle_on = 1'b1;
   logic hold_req = 1'b0;

   block_sparse_column_spmv u_dut (.*);

   spmv_result_checker u_checker (.*);

   initial begin
      forever #4 clock = ~clock;
   end

   // send one transaction, with an occasional idle gap before it
   task automatic send_block(input logic op, input logic [11:0] row,
                             input logic [15:0] w0, input logic [15:0] w1,
                             input logic [15:0] w2, input logic [15:0] w3,
                             input logic [31:0] xv);
      if (idle_on && $urandom_range(99) < 13) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_opcode   <= op;
      req_row      <= row;
      req_weight_0 <= w0;
      req_weight_1 <= w1;
      req_weight_2 <= w2;
      req_weight_3 <= w3;
      req_x_value  <= xv;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic read_row(input logic [11:0] row);
      send_block(bscs_pkg::OP_READ, row, 16'($urandom()), 16'($urandom()),
                 16'($urandom()), 16'($urandom()), $urandom());
   endtask

   // mostly moderate magnitudes so sums stay finite; sometimes any pattern
   function automatic logic [15:0] pick_weight();
      if ($urandom_range(3) != 0)
         return {1'($urandom()), 5'($urandom_range(9, 21)), 10'($urandom())};
      return 16'($urandom());
   endfunction

   function automatic logic [31:0] pick_x();
      if ($urandom_range(3) != 0)
         return {1'($urandom()), 8'($urandom_range(110, 140)), 23'($urandom())};
      return $urandom();
   endfunction

   function automatic logic [11:0] pick_row();
      case ($urandom_range(9))
         0:       return 12'($urandom());
         1:       return 12'($urandom_range(4088, 4095));
         default: return 12'($urandom_range(0, 47));
      endcase
   endfunction

   // response side: random stalls, plus one long hold-off when asked
   initial begin
      int hold_left;
      logic hold_seen;
      hold_left = 0;
      hold_seen = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_req && !hold_seen) begin
            hold_seen = 1'b1;
            hold_left = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= !(idle_on && $urandom_range(99) < 13);
         end
      end
   end

   // stimulus and verdict
   initial begin
      logic [11:0] r;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, specials, the block running off the end
      send_block(bscs_pkg::OP_ACC, 12'd0, 16'h3C00, 16'h0001, 16'h7BFF, 16'h8000,
                 32'h3F80_0000);
      send_block(bscs_pkg::OP_ACC, 12'd0, 16'h3C00, 16'h03FF, 16'hFBFF, 16'h0000,
                 32'h0000_0001);
      send_block(bscs_pkg::OP_ACC, 12'd4, 16'h7C00, 16'hFC00, 16'h7E00, 16'hFFFF,
                 32'h4000_0000);
      send_block(bscs_pkg::OP_ACC, 12'd4, 16'h3C00, 16'h3C00, 16'h3C00, 16'h3C00,
                 32'h7F80_0000);
      send_block(bscs_pkg::OP_ACC, 12'd8, 16'h7C00, 16'h3C00, 16'h0000, 16'h3C00,
                 32'h0000_0000);
      send_block(bscs_pkg::OP_ACC, 12'd9, 16'h3C00, 16'h3C00, 16'h3C00, 16'h3C00,
                 32'h7FFF_FFFF);
      send_block(bscs_pkg::OP_ACC, 12'd12, 16'h7BFF, 16'h7BFF, 16'h0001, 16'h8001,
                 32'h7F7F_FFFF);
      send_block(bscs_pkg::OP_ACC, 12'd12, 16'h7BFF, 16'h0000, 16'h3C00, 16'h3C00,
                 32'hFF7F_FFFF);
      send_block(bscs_pkg::OP_ACC, 12'd14, 16'h0001, 16'h8001, 16'h0000, 16'h0000,
                 32'h8080_0000);
      send_block(bscs_pkg::OP_ACC, 12'd4094, 16'h3C00, 16'h4000, 16'h4200, 16'h4400,
                 32'h3F80_0000);
      send_block(bscs_pkg::OP_ACC, 12'd4095, 16'hBC00, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                 32'hFFFF_FFFF);
      for (int i = 0; i < 16; i++) read_row(12'(i));
      read_row(12'd4094);
      read_row(12'd4095);
      read_row(12'd4095);

      // random: bursts into a small window of rows, reads in between
      for (int i = 0; i < 900; i++) begin
         idle_on = !(i >= 300 && i < 500);
         if (i == 600) hold_req = 1'b1;
         r = pick_row();
         if ($urandom_range(99) < 30)
            read_row(r);
         else
            send_block(bscs_pkg::OP_ACC, r, pick_weight(), pick_weight(), pick_weight(),
                       pick_weight(), pick_x());
      end
      // drain the window so late sums are seen
      for (int i = 0; i < 52; i++) read_row(12'(i));
      req_valid <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (err_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #8_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

`default_nettype wire
